FILE: design/axis_angle_rotation_matrix_macros.svh
// assertion macros for the axis angle rotation matrix checker
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define AARM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aarm check failed");

// next-cycle implication
`define AARM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aarm check failed");

`endif

FILE: design/aarm_pkg.sv
// shared constants, types and arithmetic helpers for the rotation matrix block
package aarm_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 17;
	localparam logic signed [31:0] CORDIC_INV_GAIN = 32'sd652032874;
	localparam logic signed [17:0] Q16_ONE = 18'sd65536;

	typedef logic signed [17:0] q16_t;

	// cordic phase per step, 2^32 units per turn
	function automatic logic signed [31:0] phase_step(input int i);
		logic signed [31:0] p;
		case (i)
			0: p = 32'sd536870912;
			1: p = 32'sd316933406;
			2: p = 32'sd167458907;
			3: p = 32'sd85004756;
			4: p = 32'sd42667331;
			5: p = 32'sd21354465;
			6: p = 32'sd10679838;
			7: p = 32'sd5340245;
			8: p = 32'sd2670163;
			9: p = 32'sd1335087;
			10: p = 32'sd667544;
			11: p = 32'sd333772;
			12: p = 32'sd166886;
			13: p = 32'sd83443;
			14: p = 32'sd41722;
			15: p = 32'sd20861;
			16: p = 32'sd10430;
			17: p = 32'sd5215;
			18: p = 32'sd2608;
			19: p = 32'sd1304;
			default: p = 32'sd0;
		endcase
		return p;
	endfunction

	function automatic q16_t clamp18(input logic signed [23:0] v);
		q16_t r;
		if (v > 24'sd65536)
			r = Q16_ONE;
		else if (v < -24'sd65536)
			r = -Q16_ONE;
		else
			r = v[17:0];
		return r;
	endfunction

	function automatic logic signed [35:0] mul18(input q16_t a, input q16_t b);
		logic signed [35:0] ae;
		logic signed [35:0] be;
		ae = 36'(a);
		be = 36'(b);
		return ae * be;
	endfunction

	function automatic logic signed [55:0] mul_pt(input logic signed [35:0] p,
			input logic signed [18:0] t);
		logic signed [55:0] pe;
		logic signed [55:0] te;
		pe = 56'(p);
		te = 56'(t);
		return pe * te;
	endfunction

	// floor((v + 2^31) / 2^32) then clamp to +-1.0
	function automatic q16_t round32(input logic signed [55:0] v);
		logic signed [55:0] w;
		w = v + 56'sd2147483648;
		return clamp18(w[55:32]);
	endfunction

endpackage

FILE: design/aarm_isqrt.sv
// pipelined integer square root, one root bit per stage
module aarm_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);
	import aarm_pkg::*;

	logic [33:0] rem_s [1:SQRT_STEPS];
	logic [31:0] rt_s  [1:SQRT_STEPS];
	logic [63:0] rad_s [1:SQRT_STEPS];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		logic [33:0] rem_p;
		logic [31:0] rt_p;
		logic [63:0] rad_p;
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;

		if (j == 0) begin : g_first
			assign rem_p = '0;
			assign rt_p = '0;
			assign rad_p = radicand;
		end else begin : g_next
			assign rem_p = rem_s[j];
			assign rt_p = rt_s[j];
			assign rad_p = rad_s[j];
		end

		assign cur = {rem_p, rad_p[63:62]};
		assign trial = {2'b00, rt_p, 2'b01};
		assign ge = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? 34'(cur - trial) : cur[33:0];
				rt_s[j+1] <= {rt_p[30:0], ge};
				rad_s[j+1] <= {rad_p[61:0], 2'b00};
			end
		end
	end

	assign root = rt_s[SQRT_STEPS];

endmodule

FILE: design/aarm_sincos.sv
// pipelined cordic: quadrant fold, twenty rotation stages, round and unfold
module aarm_sincos (
	input  logic                clk,
	input  logic                en,
	input  logic [15:0]         angle,
	output aarm_pkg::q16_t      cos_o,
	output aarm_pkg::q16_t      sin_o
);
	import aarm_pkg::*;

	logic signed [31:0] x_s [0:CORDIC_STEPS];
	logic signed [31:0] y_s [0:CORDIC_STEPS];
	logic signed [31:0] z_s [0:CORDIC_STEPS];
	logic [1:0]         q_s [0:CORDIC_STEPS];

	logic [16:0]        a_sum;
	logic [2:0]         qraw;
	logic signed [16:0] resid;

	assign a_sum = {1'b0, angle} + 17'd8192;
	assign qraw = a_sum[16:14];
	assign resid = $signed({1'b0, angle}) - $signed({qraw[1:0] == 2'd0 && qraw[2],
		qraw[1:0], 14'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_INV_GAIN;
			y_s[0] <= '0;
			// residual fits in 16 signed bits, scaled by 2^16
			z_s[0] <= {resid[15:0], 16'b0};
			q_s[0] <= qraw[1:0];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][31]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - phase_step(i);
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + phase_step(i);
				end
				q_s[i+1] <= q_s[i];
			end
		end
	end

	logic signed [31:0] xr;
	logic signed [31:0] yr;
	q16_t c0;
	q16_t s0;

	assign xr = (x_s[CORDIC_STEPS] + 32'sd8192) >>> 14;
	assign yr = (y_s[CORDIC_STEPS] + 32'sd8192) >>> 14;
	assign c0 = clamp18(xr[23:0]);
	assign s0 = clamp18(yr[23:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[CORDIC_STEPS])
				2'd1: begin
					cos_o <= -s0;
					sin_o <= c0;
				end
				2'd2: begin
					cos_o <= -c0;
					sin_o <= -s0;
				end
				2'd3: begin
					cos_o <= s0;
					sin_o <= -c0;
				end
				default: begin
					cos_o <= c0;
					sin_o <= s0;
				end
			endcase
		end
	end

endmodule

FILE: design/axis_angle_rotation_matrix.sv
// rodrigues rotation matrix from binary angle and unnormalised axis
// throughput: one beat per cycle while the output is not stalled, set by the fully pipelined root, divide and cordic
// a stalled output freezes every stage, so s_axis_tready follows the output register
// reset clears the stage valid bits only; data registers are not reset
module axis_angle_rotation_matrix (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // angle, axis_x, axis_y, axis_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [215:0] m_axis_tdata   // m00..m22, unit_x, unit_y, unit_z
);
	import aarm_pkg::*;

	localparam int LAST = 56;

	typedef struct packed {
		logic [2:0][15:0] mag;
		logic [2:0]       neg;
		logic [4:0]       k;
		logic             zero;
	} side_t;

	logic en;
	logic vld_s [1:LAST];

	assign en = !vld_s[LAST] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= LAST; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	// stage 1: squared length
	logic signed [15:0] ax_in [3];
	logic [31:0] sq [3];
	assign ax_in[0] = s_axis_tdata[31:16];
	assign ax_in[1] = s_axis_tdata[47:32];
	assign ax_in[2] = s_axis_tdata[63:48];
	for (genvar a = 0; a < 3; a++) begin : g_sq
		logic signed [31:0] ae;
		assign ae = 32'(ax_in[a]);
		assign sq[a] = ae * ae;
	end

	logic [31:0]        len2_s1;
	logic [15:0]        angle_s1;
	logic signed [15:0] ax_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s1 <= sq[0] + sq[1] + sq[2];
			angle_s1 <= s_axis_tdata[15:0];
			for (int a = 0; a < 3; a++)
				ax_s1[a] <= ax_in[a];
		end
	end

	// stage 2: normalise the squared length so the top bit pair is set
	logic [4:0] msb;
	logic [4:0] kk;
	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++)
			if (len2_s1[i])
				msb = 5'(i);
	end
	assign kk = 5'((6'd63 - {1'b0, msb}) >> 1);

	logic [63:0] rad_s2;
	side_t       side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2 <= {32'b0, len2_s1} << {kk, 1'b0};
			for (int a = 0; a < 3; a++) begin
				side_s2.neg[a] <= ax_s1[a][15];
				side_s2.mag[a] <= ax_s1[a][15] ? 16'(-ax_s1[a]) : ax_s1[a];
			end
			side_s2.k <= kk;
			side_s2.zero <= len2_s1 == '0;
		end
	end

	logic [31:0] root;
	aarm_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s2),
		.root     (root)
	);

	// side data waits alongside the root
	side_t side_d [0:SQRT_STEPS-1];
	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s2;
			for (int i = 1; i < SQRT_STEPS; i++)
				side_d[i] <= side_d[i-1];
		end
	end

	// stage 35: numerators, then one quotient bit per stage
	side_t side_r;
	assign side_r = side_d[SQRT_STEPS-1];

	logic [49:0] dv_rem  [0:DIV_STEPS][3];
	logic [16:0] dv_q    [0:DIV_STEPS][3];
	logic [31:0] dv_root [0:DIV_STEPS];
	logic [2:0]  dv_neg  [0:DIV_STEPS];
	logic        dv_zero [0:DIV_STEPS];

	logic [5:0]  shamt;
	logic [63:0] numer [3];
	assign shamt = {1'b0, side_r.k} + 6'd16;
	for (genvar a = 0; a < 3; a++) begin : g_num
		assign numer[a] = ({48'b0, side_r.mag[a]} << shamt) + {33'b0, root[31:1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				dv_rem[0][a] <= numer[a][49:0];
				dv_q[0][a] <= '0;
			end
			dv_root[0] <= root;
			dv_neg[0] <= side_r.neg;
			dv_zero[0] <= side_r.zero;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [49:0] dsh;
		logic [2:0]  ge;
		assign dsh = {18'b0, dv_root[j]} << (DIV_STEPS - 1 - j);
		for (genvar a = 0; a < 3; a++) begin : g_lane
			assign ge[a] = dv_rem[j][a] >= dsh;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < 3; a++) begin
					dv_rem[j+1][a] <= ge[a] ? dv_rem[j][a] - dsh : dv_rem[j][a];
					dv_q[j+1][a] <= {dv_q[j][a][15:0], ge[a]};
				end
				dv_root[j+1] <= dv_root[j];
				dv_neg[j+1] <= dv_neg[j];
				dv_zero[j+1] <= dv_zero[j];
			end
		end
	end

	// cosine and sine, delayed to meet the unit axis
	q16_t cs_cos;
	q16_t cs_sin;
	aarm_sincos u_sincos (
		.clk   (clk),
		.en    (en),
		.angle (angle_s1),
		.cos_o (cs_cos),
		.sin_o (cs_sin)
	);

	localparam int CS_DLY = 30;
	logic [35:0] cs_d [0:CS_DLY-1];
	always_ff @(posedge clk) begin
		if (en) begin
			cs_d[0] <= {cs_sin, cs_cos};
			for (int i = 1; i < CS_DLY; i++)
				cs_d[i] <= cs_d[i-1];
		end
	end

	// stage 53: signed unit axis
	q16_t u_s53 [3];
	logic zero_s53;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				logic [16:0] qm;
				qm = dv_q[DIV_STEPS][a];
				if (dv_zero[DIV_STEPS])
					u_s53[a] <= '0;
				else if (dv_neg[DIV_STEPS][a])
					u_s53[a] <= -$signed({1'b0, qm});
				else
					u_s53[a] <= $signed({1'b0, qm});
			end
			zero_s53 <= dv_zero[DIV_STEPS];
		end
	end

	q16_t c_53;
	q16_t s_53;
	assign c_53 = cs_d[CS_DLY-1][17:0];
	assign s_53 = cs_d[CS_DLY-1][35:18];

	// stage 54: pair products and axis times sine
	logic signed [35:0] pxx_s54, pyy_s54, pzz_s54, pxy_s54, pxz_s54, pyz_s54;
	logic signed [35:0] us_s54 [3];
	logic signed [18:0] t_s54;
	q16_t c_s54;
	q16_t u_s54 [3];
	logic zero_s54;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s54 <= mul18(u_s53[0], u_s53[0]);
			pyy_s54 <= mul18(u_s53[1], u_s53[1]);
			pzz_s54 <= mul18(u_s53[2], u_s53[2]);
			pxy_s54 <= mul18(u_s53[0], u_s53[1]);
			pxz_s54 <= mul18(u_s53[0], u_s53[2]);
			pyz_s54 <= mul18(u_s53[1], u_s53[2]);
			for (int a = 0; a < 3; a++) begin
				us_s54[a] <= mul18(u_s53[a], s_53);
				u_s54[a] <= u_s53[a];
			end
			t_s54 <= 19'sd65536 - {c_53[17], c_53};
			c_s54 <= c_53;
			zero_s54 <= zero_s53;
		end
	end

	// stage 55: scale by one minus cosine
	logic signed [55:0] axx_s55, ayy_s55, azz_s55, axy_s55, axz_s55, ayz_s55;
	logic signed [55:0] b_s55 [3];
	logic signed [55:0] ct_s55;
	q16_t u_s55 [3];
	logic zero_s55;

	always_ff @(posedge clk) begin
		if (en) begin
			axx_s55 <= mul_pt(pxx_s54, t_s54);
			ayy_s55 <= mul_pt(pyy_s54, t_s54);
			azz_s55 <= mul_pt(pzz_s54, t_s54);
			axy_s55 <= mul_pt(pxy_s54, t_s54);
			axz_s55 <= mul_pt(pxz_s54, t_s54);
			ayz_s55 <= mul_pt(pyz_s54, t_s54);
			for (int a = 0; a < 3; a++) begin
				b_s55[a] <= {{4{us_s54[a][35]}}, us_s54[a], 16'b0};
				u_s55[a] <= u_s54[a];
			end
			ct_s55 <= {{6{c_s54[17]}}, c_s54, 32'b0};
			zero_s55 <= zero_s54;
		end
	end

	// stage 56: sums, rounding and the zero axis override
	q16_t mat [9];
	always_comb begin
		mat[0] = round32(ct_s55 + axx_s55);
		mat[1] = round32(axy_s55 - b_s55[2]);
		mat[2] = round32(axz_s55 + b_s55[1]);
		mat[3] = round32(axy_s55 + b_s55[2]);
		mat[4] = round32(ct_s55 + ayy_s55);
		mat[5] = round32(ayz_s55 - b_s55[0]);
		mat[6] = round32(axz_s55 - b_s55[1]);
		mat[7] = round32(ayz_s55 + b_s55[0]);
		mat[8] = round32(ct_s55 + azz_s55);
		if (zero_s55) begin
			for (int i = 0; i < 9; i++)
				mat[i] = (i % 4 == 0) ? Q16_ONE : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				m_axis_tdata[18*i +: 18] <= mat[i];
			for (int a = 0; a < 3; a++)
				m_axis_tdata[162 + 18*a +: 18] <= u_s55[a];
		end
	end

endmodule

FILE: design/aarm_checker.sv
// port level checks for the rotation matrix block, bound to the top level
`include "axis_angle_rotation_matrix_macros.svh"

module aarm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [215:0] m_axis_tdata
);

	// an empty output register never holds the pipeline back
	`AARM_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

	// a waiting result freezes the whole pipeline, input side included
	`AARM_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

	// a stalled result beat keeps its data
	`AARM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// a valid result beat carries fully known data
	`AARM_ASSERT_NOW(a_out_known, m_axis_tvalid, !$isunknown(m_axis_tdata))

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
